// ===== rtl/btc_pkg.sv =====
package btc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VID_W        = $clog2(MAX_VERTICES);
    localparam int FIELD_W      = 7;
    localparam int CFG_W        = 7;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam logic [APB_ADDR_W-3:0] REG_VERTEX_COUNT = '0;

    localparam logic OP_EDGE  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic edge_load;
        logic edge_wr_a;
        logic edge_wr_b;
        logic start;
        logic sweep_rd;
        logic sweep_restart;
        logic out_fail;
        logic out_vertex;
        logic clear_rows;
    } btc_cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic vidx_last;
        logic changed;
        logic fail;
        logic out_last;
        logic out_failed;
    } btc_stat_t;

    // count 0 acts as 1, anything above the store size as the store size
    function automatic logic [FIELD_W-1:0] eff_count(input logic [CFG_W-1:0] vc);
        logic [FIELD_W-1:0] n;
        n = FIELD_W'(vc);
        if (n == '0)
            n = FIELD_W'(1);
        else if (n > FIELD_W'(MAX_VERTICES))
            n = FIELD_W'(MAX_VERTICES);
        return n;
    endfunction

    function automatic logic [MAX_VERTICES-1:0] count_mask(input logic [FIELD_W-1:0] n);
        logic [MAX_VERTICES-1:0] m;
        for (int i = 0; i < MAX_VERTICES; i++)
            m[i] = (FIELD_W'(i) < n);
        return m;
    endfunction

endpackage

// ===== rtl/btc_ram.sv =====
module btc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/btc_dpath.sv =====
module btc_dpath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  btc_pkg::btc_cmd_t          cmd,
    output btc_pkg::btc_stat_t         stat,
    input  logic [btc_pkg::CFG_W-1:0]  vertex_count,
    input  logic [btc_pkg::FIELD_W-1:0] vertex_a,
    input  logic [btc_pkg::FIELD_W-1:0] vertex_b,
    output logic [btc_pkg::FIELD_W-1:0] vertex_index,
    output logic                       color,
    output logic                       failed,
    output logic                       last
);

    localparam int NV = btc_pkg::MAX_VERTICES;
    localparam int VW = btc_pkg::VID_W;
    localparam int FW = btc_pkg::FIELD_W;

    logic [FW-1:0] n;
    logic [NV-1:0] mask;
    logic [VW-1:0] n_last;
    logic [VW-1:0] a_idx;
    logic [VW-1:0] b_idx;

    logic [VW-1:0] a_reg;
    logic [VW-1:0] b_reg;
    logic [VW-1:0] vidx_reg, vidx_next;
    logic [VW-1:0] pidx_reg;
    logic          pvalid_reg;
    logic          rvalid_reg;
    logic [NV-1:0] row_valid_reg, row_valid_next;
    logic [NV-1:0] visited_reg, visited_next;
    logic [NV-1:0] color_reg, color_next;
    logic          changed_reg, changed_next;
    logic          conflict_reg, conflict_next;

    logic [FW-1:0] out_index_reg;
    logic          out_color_reg;
    logic          out_failed_reg;
    logic          out_last_reg;

    logic          ram_we;
    logic [VW-1:0] ram_waddr;
    logic [NV-1:0] ram_wdata;
    logic [VW-1:0] ram_raddr;
    logic [NV-1:0] ram_q;

    logic [NV-1:0] old_row;
    logic [NV-1:0] row;
    logic [NV-1:0] nxt;
    logic [NV-1:0] same;
    logic          vis_p;
    logic          col_p;

    assign n      = btc_pkg::eff_count(vertex_count);
    assign mask   = btc_pkg::count_mask(n);
    assign n_last = VW'(n - FW'(1));
    assign a_idx  = VW'(vertex_a - FW'(1));
    assign b_idx  = VW'(vertex_b - FW'(1));

    assign stat.edge_ok    = (vertex_a != '0) && (vertex_a <= n)
                          && (vertex_b != '0) && (vertex_b <= n);
    assign stat.vidx_last  = (vidx_reg == n_last);
    assign stat.changed    = changed_reg;
    assign stat.fail       = conflict_reg || ((visited_reg & mask) != mask);
    assign stat.out_last   = out_last_reg;
    assign stat.out_failed = out_failed_reg;

    btc_ram #(
        .WIDTH (NV),
        .DEPTH (NV)
    ) u_adj (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // a row never written since the last clear reads as empty
    assign old_row = rvalid_reg ? ram_q : '0;
    assign row     = old_row & mask;
    assign vis_p   = visited_reg[pidx_reg];
    assign col_p   = color_reg[pidx_reg];
    assign nxt     = row & ~visited_reg;
    assign same    = col_p ? (visited_reg & color_reg) : (visited_reg & ~color_reg);

    always_comb
    begin
        priority if (cmd.edge_load)
            ram_raddr = a_idx;
        else if (cmd.edge_wr_a)
            ram_raddr = b_reg;
        else
            ram_raddr = vidx_reg;
    end

    assign ram_we    = cmd.edge_wr_a | cmd.edge_wr_b;
    assign ram_waddr = cmd.edge_wr_a ? a_reg : b_reg;
    assign ram_wdata = old_row | (cmd.edge_wr_a ? (NV'(1) << b_reg) : (NV'(1) << a_reg));

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (cmd.clear_rows)
            row_valid_next = '0;
        else if (cmd.edge_wr_a)
            row_valid_next[a_reg] = 1'b1;
        else if (cmd.edge_wr_b)
            row_valid_next[b_reg] = 1'b1;
    end

    // Colors stop moving on a sweep that adds nothing, so the conflict
    // flag gathered during that sweep is the final one.
    always_comb
    begin
        visited_next  = visited_reg;
        color_next    = color_reg;
        changed_next  = changed_reg;
        conflict_next = conflict_reg;
        if (cmd.start)
        begin
            visited_next  = NV'(1);
            color_next    = '0;
            changed_next  = 1'b0;
            conflict_next = 1'b0;
        end
        else if (cmd.sweep_restart)
        begin
            changed_next  = 1'b0;
            conflict_next = 1'b0;
        end
        else if (pvalid_reg && vis_p)
        begin
            visited_next = visited_reg | nxt;
            if (!col_p)
                color_next = color_reg | nxt;
            if (nxt != '0)
                changed_next = 1'b1;
            if ((row & same) != '0)
                conflict_next = 1'b1;
        end
    end

    always_comb
    begin
        vidx_next = vidx_reg;
        if (cmd.start)
            vidx_next = '0;
        else if (cmd.sweep_rd || cmd.out_vertex)
            vidx_next = (vidx_reg == n_last) ? '0 : vidx_reg + VW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vidx_reg      <= '0;
            pvalid_reg    <= 1'b0;
            rvalid_reg    <= 1'b0;
            row_valid_reg <= '0;
            visited_reg   <= '0;
            color_reg     <= '0;
            changed_reg   <= 1'b0;
            conflict_reg  <= 1'b0;
        end
        else
        begin
            vidx_reg      <= vidx_next;
            pvalid_reg    <= cmd.sweep_rd;
            rvalid_reg    <= row_valid_reg[ram_raddr];
            row_valid_reg <= row_valid_next;
            visited_reg   <= visited_next;
            color_reg     <= color_next;
            changed_reg   <= changed_next;
            conflict_reg  <= conflict_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= vidx_reg;
        if (cmd.edge_load)
        begin
            a_reg <= a_idx;
            b_reg <= b_idx;
        end
        if (cmd.out_fail)
        begin
            out_index_reg  <= '0;
            out_color_reg  <= 1'b0;
            out_failed_reg <= 1'b1;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.out_vertex)
        begin
            out_index_reg  <= FW'(vidx_reg) + FW'(1);
            out_color_reg  <= color_reg[vidx_reg];
            out_failed_reg <= 1'b0;
            out_last_reg   <= (vidx_reg == n_last);
        end
    end

    assign vertex_index = out_index_reg;
    assign color        = out_color_reg;
    assign failed       = out_failed_reg;
    assign last         = out_last_reg;

endmodule

// ===== rtl/btc_ctrl.sv =====
module btc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    output logic               out_valid,
    input  logic               out_ready,
    input  btc_pkg::btc_stat_t stat,
    output btc_pkg::btc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_A,
        S_EDGE_B,
        S_SWEEP,
        S_DRAIN,
        S_DECIDE,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_accept;
    logic   out_accept;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid_reg && out_ready;
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (opcode)
                        btc_pkg::OP_START:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_SWEEP;
                        end
                        btc_pkg::OP_EDGE:
                        begin
                            // drop edges with an endpoint out of range
                            if (stat.edge_ok)
                            begin
                                cmd.edge_load = 1'b1;
                                state_next    = S_EDGE_A;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_EDGE_A:
            begin
                cmd.edge_wr_a = 1'b1;
                state_next    = S_EDGE_B;
            end
            S_EDGE_B:
            begin
                cmd.edge_wr_b = 1'b1;
                state_next    = S_IDLE;
            end
            S_SWEEP:
            begin
                cmd.sweep_rd = 1'b1;
                if (stat.vidx_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.changed)
                begin
                    cmd.sweep_restart = 1'b1;
                    state_next        = S_SWEEP;
                end
                else
                begin
                    if (stat.fail)
                        cmd.out_fail = 1'b1;
                    else
                        cmd.out_vertex = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_accept)
                begin
                    if (stat.out_last)
                    begin
                        // the store survives a failed check
                        cmd.clear_rows = !stat.out_failed;
                        out_valid_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.out_vertex = 1'b1;
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
                state_next     = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/bipartite_two_coloring.sv =====
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   opcode, vertex_a, vertex_b
// out      output     out_valid / out_ready vertex_index, color, failed, last
// cfg      input      APB write, paddr      vertex_count (index 0)
//
// An edge item is accepted, then takes one read-modify-write per
// direction on the single write port of the adjacency RAM.
// A start item runs P sweeps over the N rows (one RAM read a cycle, then a
// drain and a decide state), where P is the number of sweeps until one adds
// no vertex (1 to N), followed by N color results or one failure result.
// Reset clears the per-row valid flags at once; there is no clearing pass.
// Input is taken only while idle; results hold while out_ready is low.
module bipartite_two_coloring (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [btc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [btc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [btc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic [btc_pkg::FIELD_W-1:0]         vertex_a,
    input  logic [btc_pkg::FIELD_W-1:0]         vertex_b,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [btc_pkg::FIELD_W-1:0]         vertex_index,
    output logic                                color,
    output logic                                failed,
    output logic                                last
);

    logic [btc_pkg::CFG_W-1:0] vertex_count_reg;
    logic                      cfg_write;
    logic                      sel_count;
    btc_pkg::btc_cmd_t         cmd;
    btc_pkg::btc_stat_t        stat;

    assign pready    = 1'b1;
    assign sel_count = (paddr[btc_pkg::APB_ADDR_W-1:2] == btc_pkg::REG_VERTEX_COUNT);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= btc_pkg::CFG_W'(1);
        end
        else if (cfg_write && sel_count)
        begin
            vertex_count_reg <= pwdata[btc_pkg::CFG_W-1:0];
        end
    end

    assign prdata = sel_count ? btc_pkg::APB_DATA_W'(vertex_count_reg) : '0;

    btc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    btc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .vertex_count (vertex_count_reg),
        .vertex_a     (vertex_a),
        .vertex_b     (vertex_b),
        .vertex_index (vertex_index),
        .color        (color),
        .failed       (failed),
        .last         (last)
    );

endmodule

// ===== rtl/btc_checker.sv =====
module btc_assertions (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [btc_pkg::FIELD_W-1:0] vertex_index,
    input logic                        color,
    input logic                        failed,
    input logic                        last
);

    // no new item is taken while a run still has results to deliver
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while results pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && failed) |-> (last && (vertex_index == '0) && !color))
        else $error("malformed failure item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !failed) |-> (vertex_index != '0))
        else $error("color item with vertex 0");

    // colors of one run follow each other without gaps, in index order
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=>
            (out_valid && !failed && (vertex_index == $past(vertex_index) + 1'b1)))
        else $error("color sequence broken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(vertex_index) && $stable(color)
             && $stable(failed) && $stable(last)))
        else $error("stalled item changed");

endmodule

bind bipartite_two_coloring btc_assertions u_btc_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vertex_index (vertex_index),
    .color        (color),
    .failed       (failed),
    .last         (last)
);

// ===== verif/btc_checker.sv =====
`timescale 1ns / 1ps

package btc_tb_pkg;

    // register index with nothing behind it
    localparam int   REG_SPARE = 1;

endpackage

module btc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [btc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [btc_pkg::APB_DATA_W-1:0]      pwdata,
    input  logic                                pready,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                opcode,
    input  logic [btc_pkg::FIELD_W-1:0]         vertex_a,
    input  logic [btc_pkg::FIELD_W-1:0]         vertex_b,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [btc_pkg::FIELD_W-1:0]         vertex_index,
    input  logic                                color,
    input  logic                                failed,
    input  logic                                last,
    output int                                  errors,
    output int                                  pending
);

    import btc_pkg::*;
    import btc_tb_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] vidx;
        logic               col;
        logic               fail;
        logic               lst;
    } color_res_t;

    logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
    logic [CFG_W-1:0]        vcount_q;
    color_res_t              color_q [$];
    color_res_t              want;
    int                      mismatch_cnt = 0;
    int                      queued_cnt   = 0;

    assign errors  = mismatch_cnt;
    assign pending = queued_cnt;

    function automatic int active_vertices();
        int n;
        n = vcount_q;
        if (n < 1)
            n = 1;
        if (n > MAX_VERTICES)
            n = MAX_VERTICES;
        return n;
    endfunction

    task automatic add_link(input int a, input int b);
        int n;
        n = active_vertices();
        // out-of-range endpoints are dropped silently
        if (a < 1 || a > n || b < 1 || b > n)
            return;
        adj_rows[a-1][b-1] = 1'b1;
        adj_rows[b-1][a-1] = 1'b1;
    endtask

    task automatic run_coloring();
        int                      n;
        int                      lvl;
        bit                      clash;
        logic [MAX_VERTICES-1:0] mask;
        logic [MAX_VERTICES-1:0] nxt;
        logic [MAX_VERTICES-1:0] seen;
        logic [MAX_VERTICES-1:0] front;
        logic [MAX_VERTICES-1:0] colors;
        logic [MAX_VERTICES-1:0] same_set;
        color_res_t              r;
        n = active_vertices();
        mask = (n >= MAX_VERTICES) ? '1 : ((MAX_VERTICES'(1) << n) - 1'b1);
        seen = MAX_VERTICES'(1);
        front = MAX_VERTICES'(1);
        colors = '0;
        lvl = 0;
        clash = 0;
        // walk level by level; odd distance gets color 1
        while (front != '0)
        begin
            nxt = '0;
            for (int v = 0; v < n; v++)
                if (front[v])
                    nxt |= adj_rows[v];
            nxt &= mask & ~seen;
            lvl++;
            if (lvl % 2 == 1)
                colors |= nxt;
            seen |= nxt;
            front = nxt;
        end
        for (int v = 0; v < n; v++)
        begin
            if (seen[v])
            begin
                same_set = colors[v] ? (colors & seen) : (seen & ~colors);
                if ((adj_rows[v] & mask & same_set) != '0)
                    clash = 1;
            end
        end
        if (clash || (seen & mask) != mask)
        begin
            r.vidx = '0;
            r.col = 1'b0;
            r.fail = 1'b1;
            r.lst = 1'b1;
            color_q = {color_q, r};
        end
        else
        begin
            for (int v = 0; v < n; v++)
            begin
                r.vidx = FIELD_W'(v + 1);
                r.col = colors[v];
                r.fail = 1'b0;
                r.lst = (v == n - 1);
                color_q = {color_q, r};
            end
            // a clean pass empties the store
            for (int v = 0; v < MAX_VERTICES; v++)
                adj_rows[v] = '0;
        end
    endtask

    task automatic check_field(input string label, input logic [FIELD_W-1:0] exp_val,
                               input logic [FIELD_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, label, exp_val, act_val);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < MAX_VERTICES; v++)
                adj_rows[v] = '0;
            vcount_q = CFG_W'(1);
            color_q.delete();
            queued_cnt = 0;
        end
        else
        begin
            // results out first: an item accepted now cannot have produced one yet
            if (out_valid && out_ready)
            begin
                if (color_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                             $time, vertex_index, color, failed, last);
                    mismatch_cnt++;
                end
                else
                begin
                    want = color_q.pop_front();
                    check_field("vertex_index", want.vidx, vertex_index);
                    check_field("color", FIELD_W'(want.col), FIELD_W'(color));
                    check_field("failed", FIELD_W'(want.fail), FIELD_W'(failed));
                    check_field("last", FIELD_W'(want.lst), FIELD_W'(last));
                end
            end
            if (in_valid && in_ready)
            begin
                if (opcode == OP_START)
                    run_coloring();
                else
                    add_link(vertex_a, vertex_b);
            end
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_W-1:2] == REG_VERTEX_COUNT)
                vcount_q = pwdata[CFG_W-1:0];
            queued_cnt = color_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import btc_pkg::*;
    import btc_tb_pkg::*;

    localparam int LIMIT      = 2000000;
    localparam int IDLE_PAUSE = 16;
    localparam int HOLD_LEN   = 600;

    typedef enum {GRAPH_GOOD, GRAPH_ODD, GRAPH_SPLIT} graph_kind_t;
    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   opcode = OP_EDGE;
    logic [FIELD_W-1:0]     vertex_a = '0;
    logic [FIELD_W-1:0]     vertex_b = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [FIELD_W-1:0]     vertex_index;
    logic                   color;
    logic                   failed;
    logic                   last;

    int fail_count;
    int pending_count;
    int cycle_cnt = 0;
    int burst_left = 0;
    int cur_n = 1;
    int graph_items = 0;
    int depth_of [MAX_VERTICES+1];
    bit squeeze_armed = 0;
    bit squeeze_done = 0;

    bipartite_two_coloring i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .vertex_a     (vertex_a),
        .vertex_b     (vertex_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_index (vertex_index),
        .color        (color),
        .failed       (failed),
        .last         (last)
    );

    btc_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .vertex_a     (vertex_a),
        .vertex_b     (vertex_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_index (vertex_index),
        .color        (color),
        .failed       (failed),
        .last         (last),
        .errors       (fail_count),
        .pending      (pending_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: changing stall patterns plus one long hold-off
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        mode = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else if (squeeze_armed && !squeeze_done && out_valid)
            begin
                squeeze_done = 1;
                hold_left = HOLD_LEN;
                out_ready = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   out_ready = 1'b1;
                    RX_COIN:   out_ready = $urandom_range(0, 1);
                    RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
                    default:   out_ready = (mode_left % 6) < 4;
                endcase
            end
        end
    end

    task automatic put_item(input logic op, input int a, input int b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        opcode = op;
        vertex_a = FIELD_W'(a);
        vertex_b = FIELD_W'(b);
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic add_edge(input int a, input int b);
        if (a >= 1 && a <= cur_n && b >= 1 && b <= cur_n)
            graph_items++;
        put_item(OP_EDGE, a, b);
    endtask

    task automatic add_edge_any(input int a, input int b);
        if ($urandom_range(0, 1))
            add_edge(a, b);
        else
            add_edge(b, a);
    endtask

    task automatic start_check();
        graph_items++;
        // endpoint fields carry junk on a start
        put_item(OP_START, $urandom_range(0, 127), $urandom_range(0, 127));
    endtask

    task automatic write_reg(input int idx, input int value);
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        // an edge leaves no result behind, so let it finish
        repeat (IDLE_PAUSE) @(negedge clk);
        pwdata = $urandom();
        pwdata[CFG_W-1:0] = CFG_W'(value);
        paddr = APB_ADDR_W'(idx * 4);
        pwrite = 1'b1;
        psel = 1'b1;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        burst_left = 0;
    endtask

    task automatic set_count(input int value);
        write_reg(REG_VERTEX_COUNT, value);
        cur_n = (value == 0) ? 1 : ((value > MAX_VERTICES) ? MAX_VERTICES : value);
    endtask

    // random spanning tree, then extra edges across parity, then breakage
    task automatic build_graph(input int n, input graph_kind_t kind);
        int skip;
        int u;
        int x;
        int y;
        int extra;
        skip = (kind == GRAPH_SPLIT) ? $urandom_range(2, n) : 0;
        depth_of[1] = 0;
        for (int v = 2; v <= n; v++)
        begin
            if (v != skip)
            begin
                do
                    u = $urandom_range(1, v - 1);
                while (u == skip);
                depth_of[v] = depth_of[u] + 1;
                add_edge_any(u, v);
            end
        end
        extra = $urandom_range(0, n / 2);
        repeat (extra)
        begin
            x = $urandom_range(1, n);
            y = $urandom_range(1, n);
            if (x != skip && y != skip && (depth_of[x] % 2) != (depth_of[y] % 2))
                add_edge_any(x, y);
        end
        if ($urandom_range(0, 3) == 0)
            add_edge_any($urandom_range(1, n),
                         $urandom_range(0, 1) ? 0 : $urandom_range(n + 1, 127));
        if (kind == GRAPH_ODD)
        begin
            // same parity, or a self-loop away from vertex 1
            do
            begin
                x = $urandom_range(2, n);
                y = $urandom_range(1, n);
            end
            while ((depth_of[x] % 2) != (depth_of[y] % 2));
            add_edge_any(x, y);
        end
    endtask

    initial
    begin
        int          seq;
        int          n;
        bit          reuse_ok;
        graph_kind_t kind;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // count after reset is one vertex
        start_check();
        // zero counts as one; the spare index must not disturb it
        set_count(0);
        write_reg(REG_SPARE, 9);
        start_check();
        set_count(2);
        add_edge(1, 2);
        start_check();
        // reversed endpoints plus dropped edges
        set_count(3);
        add_edge(2, 1);
        add_edge(3, 2);
        add_edge(0, 3);
        add_edge(127, 127);
        start_check();
        // self-loop fails; a count of two then passes and clears
        set_count(4);
        add_edge(1, 2);
        add_edge(2, 3);
        add_edge(3, 4);
        add_edge(3, 3);
        start_check();
        set_count(2);
        start_check();
        // odd cycle fails; shrinking the count hides the stale rows
        set_count(5);
        add_edge(1, 2);
        add_edge(2, 3);
        add_edge(3, 4);
        add_edge(4, 5);
        add_edge(5, 1);
        start_check();
        set_count(3);
        start_check();
        // count above the store size, nothing reached
        set_count(127);
        start_check();

        graph_items = 0;
        seq = 0;
        reuse_ok = 0;
        while (graph_items < 85)
        begin
            if (seq == 3)
            begin
                n = MAX_VERTICES;
                kind = GRAPH_GOOD;
            end
            else if (seq == 1 || (reuse_ok && $urandom_range(0, 2) == 0))
            begin
                n = cur_n;
                kind = GRAPH_GOOD;
            end
            else
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(2, 9);
                if (seq == 0 || $urandom_range(0, 2) != 0)
                    kind = GRAPH_GOOD;
                else
                    kind = $urandom_range(0, 1) ? GRAPH_ODD : GRAPH_SPLIT;
            end
            if (seq == 3)
                set_count($urandom_range(MAX_VERTICES, 127));
            else if (n != cur_n)
                set_count(n);
            build_graph(n, kind);
            // hold off on these results while the next graph is offered
            if (seq == 0)
                squeeze_armed = 1;
            start_check();
            reuse_ok = (kind == GRAPH_GOOD);
            // a failed check keeps its edges; a one-vertex pass wipes them
            if (kind != GRAPH_GOOD)
            begin
                set_count(1);
                start_check();
            end
            seq++;
        end

        // self-loop on the root vertex
        set_count(2);
        add_edge(1, 1);
        add_edge(2, 1);
        start_check();

        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/btc_pkg.sv
rtl/btc_ram.sv
rtl/btc_dpath.sv
rtl/btc_ctrl.sv
rtl/bipartite_two_coloring.sv
rtl/btc_checker.sv
verif/btc_checker.sv
verif/tb_top.sv
